[rtl/fltw_pkg.sv]
// Package for the four-level page table walker: widths, field codes and
// the per-level index select. Depends on nothing; imported by the walker top level.
package fltw_pkg;

    localparam int LEVEL_COUNT    = 4;
    localparam int INDEX_BITS     = 9;
    localparam int READ_ADDR_BITS = 36;
    localparam int PAGE_BITS      = 12;
    localparam int ADDR_BITS      = 52;
    localparam int DATA_BITS      = 64;
    localparam int VA_KEEP_BITS   = PAGE_BITS + INDEX_BITS * LEVEL_COUNT;
    localparam int LVL_BITS       = $clog2(LEVEL_COUNT);

    localparam logic [DATA_BITS-1:0] PTE_FRAME_MASK   = 64'h000f_ffff_ffff_f000;
    localparam logic [DATA_BITS-1:0] DIRECT_MAP_START = 64'hffff_ff80_0000_0000;

    // Input beat kinds.
    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_READ_DATA = 1'b1;

    // Result beat kinds.
    localparam logic RESULT_READ_REQ  = 1'b0;
    localparam logic RESULT_PHYS_ADDR = 1'b1;

    typedef logic [VA_KEEP_BITS-1:0]   va_t;
    typedef logic [READ_ADDR_BITS-1:0] raddr_t;
    typedef logic [LVL_BITS-1:0]       lvl_t;

    function automatic logic [INDEX_BITS-1:0] level_index(input va_t va, input lvl_t lvl);
        logic [INDEX_BITS-1:0] idx;
        idx = '0;
        for (int l = 0; l < LEVEL_COUNT; l++)
        begin
            if (lvl == LVL_BITS'(l))
            begin
                idx = va[PAGE_BITS + INDEX_BITS * l +: INDEX_BITS];
            end
        end
        return idx;
    endfunction

    // Table base plus eight bytes per index, kept to the read address width.
    function automatic raddr_t read_address(input raddr_t base, input va_t va, input lvl_t lvl);
        raddr_t offset;
        offset = raddr_t'({level_index(va, lvl), 3'b000});
        return base + offset;
    endfunction

endpackage

[rtl/four_level_page_table_walker_unit.sv]
// Four-level page table walker top level: input register, walk state and
// result register. Depends on fltw_pkg.
//
// Channel | Direction | Handshake           | Payload
// cfg     | in        | cfg_wr_en           | cfg_wr_data (root table base)
// in      | in        | in_valid / in_ready | kind, virt_addr, read_data
// out     | out       | out_valid/out_ready | result_kind, address
//
// A beat is taken every cycle while the output does not stall; each beat waits
// in the input register, and its result, if any, is loaded into the result
// register as the beat leaves the input register.
// The input register advances whenever the result register is empty or being
// emptied, so a stalled output holds off the input by one beat of slack.
// Reset clears the walk state, the root base and both valid flags.
module four_level_page_table_walker_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [fltw_pkg::DATA_BITS-1:0]   cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [fltw_pkg::DATA_BITS-1:0]   virt_addr,
    input  logic [fltw_pkg::DATA_BITS-1:0]   read_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             result_kind,
    output logic [fltw_pkg::ADDR_BITS-1:0]   address
);
    import fltw_pkg::*;

    logic [DATA_BITS-1:0] root_reg;

    logic                 s1_valid_reg;
    logic                 s1_kind_reg;
    logic [DATA_BITS-1:0] s1_va_reg;
    logic [DATA_BITS-1:0] s1_data_reg;

    logic   walk_busy_reg, walk_busy_next;
    lvl_t   levels_left_reg, levels_left_next;
    va_t    held_va_reg, held_va_next;
    raddr_t base_reg, base_next;

    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;

    logic                 out_free;
    logic                 s1_fire;
    logic                 has_result;
    logic                 res_kind;
    logic [ADDR_BITS-1:0] res_addr;
    va_t                  new_va;
    raddr_t               root_base;
    raddr_t               entry_base;
    lvl_t                 lvl_dec;
    logic [DATA_BITS-1:0] final_sum;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    assign new_va     = s1_va_reg[VA_KEEP_BITS-1:0];
    assign root_base  = root_reg[READ_ADDR_BITS-1:0];
    assign entry_base = READ_ADDR_BITS'((s1_data_reg & PTE_FRAME_MASK) + DIRECT_MAP_START);
    assign lvl_dec    = levels_left_reg - 1'b1;
    assign final_sum  = (s1_data_reg & PTE_FRAME_MASK)
                      + DATA_BITS'(held_va_reg[PAGE_BITS-1:0]);

    always_comb
    begin
        walk_busy_next   = walk_busy_reg;
        levels_left_next = levels_left_reg;
        held_va_next     = held_va_reg;
        base_next        = base_reg;
        has_result       = 1'b0;
        res_kind         = RESULT_READ_REQ;
        res_addr         = '0;
        if (s1_fire)
        begin
            if (s1_kind_reg == KIND_TRANSLATE)
            begin
                if (!walk_busy_reg)
                begin
                    walk_busy_next   = 1'b1;
                    levels_left_next = LVL_BITS'(LEVEL_COUNT - 1);
                    held_va_next     = new_va;
                    base_next        = root_base;
                    has_result       = 1'b1;
                    res_addr         = ADDR_BITS'(read_address(root_base, new_va,
                                                    LVL_BITS'(LEVEL_COUNT - 1)));
                end
            end
            else if (walk_busy_reg)
            begin
                has_result = 1'b1;
                if (levels_left_reg != '0)
                begin
                    levels_left_next = lvl_dec;
                    base_next        = entry_base;
                    res_addr         = ADDR_BITS'(read_address(entry_base, held_va_reg,
                                                               lvl_dec));
                end
                else
                begin
                    // Last level: the entry's frame plus the page offset.
                    walk_busy_next = 1'b0;
                    res_kind       = RESULT_PHYS_ADDR;
                    res_addr       = final_sum[ADDR_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            walk_busy_reg   <= 1'b0;
            levels_left_reg <= '0;
            held_va_reg     <= '0;
            base_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                root_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            walk_busy_reg   <= walk_busy_next;
            levels_left_reg <= levels_left_next;
            held_va_reg     <= held_va_next;
            base_reg        <= base_next;
            if (s1_fire && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_kind_reg <= kind;
            s1_va_reg   <= virt_addr;
            s1_data_reg <= read_data;
        end
        if (s1_fire && has_result)
        begin
            out_kind_reg <= res_kind;
            out_addr_reg <= res_addr;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign address     = out_addr_reg;

    // An idle walker always sits at level zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !walk_busy_reg |-> levels_left_reg == '0)
        else $error("idle walker with levels left");

    // A read request never reaches beyond the read address width.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == RESULT_READ_REQ
            |-> (out_addr_reg >> READ_ADDR_BITS) == '0)
        else $error("read request address too wide");

    // Finishing a walk leaves the walker idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && has_result && res_kind == RESULT_PHYS_ADDR |=> !walk_busy_reg)
        else $error("walker still busy after final result");

    // An empty result register never holds off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for four_level_page_table_walker_unit: random and directed
// beats, a behavioral walk predictor and a result scoreboard. Depends on fltw_pkg.
module tb;

    import fltw_pkg::*;

    typedef struct packed
    {
        logic                 kind;
        logic [DATA_BITS-1:0] va;
        logic [DATA_BITS-1:0] data;
    } beat_t;

    typedef struct packed
    {
        logic                 rkind;
        logic [ADDR_BITS-1:0] addr;
    } walk_result_t;

    localparam int SETTLE_CYCLES = 8;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [DATA_BITS-1:0] cfg_wr_data = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 kind        = 1'b0;
    logic [DATA_BITS-1:0] virt_addr   = '0;
    logic [DATA_BITS-1:0] read_data   = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b1;
    logic                 result_kind;
    logic [ADDR_BITS-1:0] address;

    // Predictor state, kept apart from the block.
    logic [DATA_BITS-1:0] root_base_m   = '0;
    logic                 walking_m     = 1'b0;
    lvl_t                 levels_to_go  = '0;
    va_t                  latched_va    = '0;
    raddr_t               table_base_m  = '0;

    beat_t        pending_beats[$];
    walk_result_t expected_results[$];
    int           error_count = 0;

    int in_gap      = 0;
    bit in_no_idle  = 1'b0;
    int out_stall   = 0;
    bit out_no_idle = 1'b0;

    four_level_page_table_walker_unit uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .virt_addr   (virt_addr),
        .read_data   (read_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .address     (address)
    );

    always #2 clk = ~clk;

    function automatic logic [DATA_BITS-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Most gaps are short, a few are long.
    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic raddr_t table_read_addr(input raddr_t base, input va_t va,
                                               input lvl_t lvl);
        va_t    shifted;
        raddr_t offset;
        shifted = va >> (PAGE_BITS + INDEX_BITS * int'(lvl));
        offset  = raddr_t'(shifted[INDEX_BITS-1:0]) << 3;
        return base + offset;
    endfunction

    // Advances the walk model by one accepted beat; returns 1 when a result follows.
    function automatic bit walk_predict(input beat_t b, output walk_result_t r);
        logic [DATA_BITS-1:0] frame;
        logic [DATA_BITS-1:0] sum;
        r = '0;
        frame = b.data & PTE_FRAME_MASK;
        if (b.kind == KIND_TRANSLATE)
        begin
            if (walking_m)
                return 1'b0;
            walking_m    = 1'b1;
            levels_to_go = lvl_t'(LEVEL_COUNT - 1);
            latched_va   = b.va[VA_KEEP_BITS-1:0];
            table_base_m = root_base_m[READ_ADDR_BITS-1:0];
            r.rkind = RESULT_READ_REQ;
            r.addr  = ADDR_BITS'(table_read_addr(table_base_m, latched_va, levels_to_go));
            return 1'b1;
        end
        if (!walking_m)
            return 1'b0;
        if (levels_to_go != '0)
        begin
            sum          = frame + DIRECT_MAP_START;
            table_base_m = sum[READ_ADDR_BITS-1:0];
            levels_to_go = levels_to_go - 1'b1;
            r.rkind = RESULT_READ_REQ;
            r.addr  = ADDR_BITS'(table_read_addr(table_base_m, latched_va, levels_to_go));
            return 1'b1;
        end
        walking_m = 1'b0;
        sum       = frame + DATA_BITS'(latched_va[PAGE_BITS-1:0]);
        r.rkind   = RESULT_PHYS_ADDR;
        r.addr    = sum[ADDR_BITS-1:0];
        return 1'b1;
    endfunction

    // Input driver: predicts each beat as it is accepted, then loads the next one.
    always @(posedge clk)
    begin
        walk_result_t res;
        beat_t        nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (walk_predict('{kind, virt_addr, read_data}, res))
                    expected_results.push_back(res);
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    nxt = pending_beats.pop_front();
                    kind      <= nxt.kind;
                    virt_addr <= nxt.va;
                    read_data <= nxt.data;
                    in_valid  <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        in_no_idle = ~in_no_idle;
                    in_gap = pick_gap(in_no_idle);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and output back-pressure.
    always @(posedge clk)
    begin
        walk_result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat: result_kind %0d address %h",
                           result_kind, address);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result_kind !== exp_r.rkind)
                    begin
                        $error("result_kind: expected %0d, got %0d", exp_r.rkind, result_kind);
                        error_count++;
                    end
                    if (address !== exp_r.addr)
                    begin
                        $error("address: expected %h, got %h", exp_r.addr, address);
                        error_count++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    out_no_idle = ~out_no_idle;
                out_stall = pick_gap(out_no_idle);
                out_ready <= (out_stall == 0);
            end
        end
    end

    task automatic push_beat(input logic k, input logic [DATA_BITS-1:0] va,
                             input logic [DATA_BITS-1:0] data);
        @(negedge clk);
        pending_beats.push_back('{k, va, data});
    endtask

    // Waits until every beat is sent and every result is back, then lets the
    // pipeline empty of beats that produce nothing.
    task automatic settle();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_root(input logic [DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        root_base_m = value;
    endtask

    // Mostly complete walks with random entries; the rest are stray read data,
    // requests in the middle of a walk and walks cut short.
    task automatic random_phase(input int count);
        int sent;
        int pick;
        int reads;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                push_beat(KIND_READ_DATA, rand64(), rand64());
                sent++;
            end
            else
            begin
                reads = (pick < 14) ? $urandom_range(1, 3) : LEVEL_COUNT;
                push_beat(KIND_TRANSLATE, rand64(), rand64());
                sent++;
                for (int i = 0; i < reads; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        push_beat(KIND_TRANSLATE, rand64(), rand64());
                        sent++;
                    end
                    push_beat(KIND_READ_DATA, rand64(), rand64());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [DATA_BITS-1:0] ones;
        ones = '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Highest root, so the root-level read address wraps at the read width.
        write_root(ones);
        push_beat(KIND_READ_DATA, rand64(), ones);
        push_beat(KIND_TRANSLATE, ones, '0);
        push_beat(KIND_READ_DATA, '0, ones);
        push_beat(KIND_TRANSLATE, '0, '0);
        push_beat(KIND_READ_DATA, ones, ones);
        push_beat(KIND_READ_DATA, ones, ones);
        push_beat(KIND_READ_DATA, ones, ones);
        settle();

        write_root('0);
        push_beat(KIND_TRANSLATE, '0, ones);
        repeat (LEVEL_COUNT) push_beat(KIND_READ_DATA, ones, '0);
        // High virtual address bits above the walked levels must not matter.
        push_beat(KIND_TRANSLATE, 64'hffff_0000_0000_0fff, '0);
        push_beat(KIND_READ_DATA, '0, 64'h5555_5555_5555_5555);
        push_beat(KIND_READ_DATA, '0, 64'haaaa_aaaa_aaaa_aaaa);
        push_beat(KIND_READ_DATA, '0, 64'h000f_ffff_ffff_f000);
        push_beat(KIND_READ_DATA, '0, 64'hfff0_0000_0000_0fff);
        settle();

        write_root(rand64());
        random_phase(110);
        settle();
        write_root(64'h0000_000f_ffff_fff8);
        random_phase(110);
        settle();
        write_root(DIRECT_MAP_START | 64'h0000_0000_0012_3000);
        random_phase(110);
        settle();
        write_root(ones);
        random_phase(110);
        settle();
        write_root(rand64());
        random_phase(110);
        settle();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
